[hw/rtl/prr_pkg.sv]
// Shared types and constants for the polyphase rational resampler.
// Holds the input/output word layouts, register codes and MAC control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

  // Fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 16;
  localparam int TAP_FRAC  = TAP_W - 4;   // Q3.12 taps
  localparam int IF_W      = 5;           // interp_factor register
  localparam int DF_W      = 9;           // decim_factor register
  localparam int TPP_W     = 6;           // taps_per_phase register
  localparam int TIDX_W    = 9;           // tap_index field
  localparam int DECIM_MAX = 256;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_INTERP = 2'd0;
  localparam logic [1:0] REG_DECIM  = 2'd1;
  localparam logic [1:0] REG_TAPS   = 2'd2;

  // Input word opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TAP    = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic                       in_last;
    logic        [TIDX_W-1:0]   tap_index;
    logic signed [TAP_W-1:0]    tap_value;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_re;
    logic signed [SAMPLE_W-1:0] out_im;
    logic                       run_last;
    logic                       block_end;
    logic                       saturated;
  } out_word_t;

  // Control that travels alongside one tap through the MAC pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // Rounded and saturated result of one output
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       sat;
  } mac_res_t;

endpackage

`default_nettype wire

[hw/rtl/prr_tap_mem.sv]
// Prototype tap store: single-port-write, registered-read memory.
// Sweeps itself to zero after reset. Depends on prr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prr_tap_mem
  import prr_pkg::*;
#(
  parameter int DEPTH = 512,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [TAP_W-1:0]  wr_data,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [TAP_W-1:0]  rd_data,
  output logic                     busy
);

  logic signed [TAP_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]       clr_addr;

  // Clear sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/prr_hist_mem.sv]
// Complex sample history line held as a circular buffer in one memory.
// A fill count masks entries not yet written. Depends on prr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prr_hist_mem
  import prr_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic signed [SAMPLE_W-1:0] push_re,
  input  logic signed [SAMPLE_W-1:0] push_im,
  input  logic                       rd_start,
  input  logic                       rd_en,
  output logic signed [SAMPLE_W-1:0] rd_re,
  output logic signed [SAMPLE_W-1:0] rd_im
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [2*SAMPLE_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]     wp;
  logic [ADDR_W-1:0]     wp_inc;
  logic [ADDR_W-1:0]     rptr;
  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      age;
  logic [2*SAMPLE_W-1:0] rd_q;
  logic                  rd_zero;

  assign wp_inc = (wp == ADDR_W'(DEPTH - 1)) ? '0 : wp + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (push) begin
      wp <= wp_inc;
      if (fill != CNT_W'(DEPTH)) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_inc] <= {push_re, push_im};
    end
  end

  // Walk from the newest sample toward older ones
  always_ff @(posedge clk) begin
    if (rd_start) begin
      rptr <= push ? wp_inc : wp;
      age  <= '0;
    end else if (rd_en) begin
      rptr <= (rptr == '0) ? ADDR_W'(DEPTH - 1) : rptr - ADDR_W'(1);
      age  <= age + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= mem[rptr];
      rd_zero <= (age >= fill);
    end
  end

  // Entries never written read as zero
  assign rd_re = rd_zero ? '0 : $signed(rd_q[2*SAMPLE_W-1:SAMPLE_W]);
  assign rd_im = rd_zero ? '0 : $signed(rd_q[SAMPLE_W-1:0]);

endmodule

`default_nettype wire

[hw/rtl/prr_mac.sv]
// Complex multiply-accumulate pipeline with rounding and saturation.
// Real tap times complex sample, one tap per cycle. Depends on prr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prr_mac
  import prr_pkg::*;
#(
  parameter int MAX_TAPS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [TAP_W-1:0]    tap,
  input  logic signed [SAMPLE_W-1:0] h_re,
  input  logic signed [SAMPLE_W-1:0] h_im,
  input  mac_ctl_t                   ctl,
  output logic                       done,
  output mac_res_t                   res
);

  localparam int PRW = SAMPLE_W + TAP_W;
  localparam int AW  = PRW + $clog2(MAX_TAPS + 1);
  localparam logic signed [AW:0] HALF = (AW+1)'(2 ** (TAP_FRAC - 1));
  localparam logic signed [AW:0] MAXV = (AW+1)'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [AW:0] MINV = ~MAXV;

  logic signed [PRW-1:0] prod_re;
  logic signed [PRW-1:0] prod_im;
  logic signed [AW-1:0]  acc_re;
  logic signed [AW-1:0]  acc_im;
  mac_ctl_t              ctl_a;
  logic [SAMPLE_W:0]     rs_re;
  logic [SAMPLE_W:0]     rs_im;

  // Returns {clip, value}: add half, floor shift, clip to sample range
  function automatic logic [SAMPLE_W:0] round_sat(input logic signed [AW-1:0] a);
    logic signed [AW:0] r;
    logic signed [AW:0] s;
    r = $signed({a[AW-1], a}) + HALF;
    s = r >>> TAP_FRAC;
    if (s > MAXV) begin
      round_sat = {1'b1, MAXV[SAMPLE_W-1:0]};
    end else if (s < MINV) begin
      round_sat = {1'b1, MINV[SAMPLE_W-1:0]};
    end else begin
      round_sat = {1'b0, s[SAMPLE_W-1:0]};
    end
  endfunction

  always_ff @(posedge clk) begin
    prod_re <= tap * h_re;
    prod_im <= tap * h_im;
    if (ctl_a.valid) begin
      acc_re <= ctl_a.first ? AW'(prod_re) : acc_re + AW'(prod_re);
      acc_im <= ctl_a.first ? AW'(prod_im) : acc_im + AW'(prod_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      done  <= 1'b0;
    end else begin
      ctl_a <= ctl;
      done  <= ctl_a.valid && ctl_a.last;
    end
  end

  assign rs_re   = round_sat(acc_re);
  assign rs_im   = round_sat(acc_im);
  assign res.re  = $signed(rs_re[SAMPLE_W-1:0]);
  assign res.im  = $signed(rs_im[SAMPLE_W-1:0]);
  assign res.sat = rs_re[SAMPLE_W] | rs_im[SAMPLE_W];

endmodule

`default_nettype wire

[hw/rtl/polyphase_rational_resampler.sv]
// Polyphase rational resampler top: APB registers, sequencer, output register.
// Uses prr_pkg, prr_tap_mem, prr_hist_mem, prr_mac.
// in_stall stays high until every output of an accepted sample is loaded into the output
//   register, so a new word is taken only while idle; tap writes and samples that emit
//   nothing leave it idle. The outputs are worked in turn by the one MAC walking one tap a cycle.
// Reset: synchronous, active high; the tap store then sweeps all
//   MAX_INTERP * MAX_TAPS_PER_PHASE entries (512 by default) to zero with in_stall high.
`timescale 1ns / 1ps
`default_nettype none

module polyphase_rational_resampler
  import prr_pkg::*;
#(
  parameter int MAX_INTERP         = 16,
  parameter int MAX_TAPS_PER_PHASE = 32
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_word,
  // Output channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_word
);

  localparam int TAP_DEPTH = MAX_INTERP * MAX_TAPS_PER_PHASE;
  localparam int TAW       = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
  localparam int KW        = $clog2(MAX_TAPS_PER_PHASE + 1);
  // Phase stays below MAX_INTERP + DECIM_MAX
  localparam int PW        = $clog2(MAX_INTERP + DECIM_MAX + 1);
  localparam int PSW       = PW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration registers, raw as written; clamped where used
  // ---------------------------------------------------------------------------
  logic [IF_W-1:0]  reg_interp;
  logic [DF_W-1:0]  reg_decim;
  logic [TPP_W-1:0] reg_taps;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_interp <= IF_W'(1);
      reg_decim  <= DF_W'(1);
      reg_taps   <= TPP_W'(1);
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:2])
        REG_INTERP: reg_interp <= pwdata[IF_W-1:0];
        REG_DECIM:  reg_decim  <= pwdata[DF_W-1:0];
        REG_TAPS:   reg_taps   <= pwdata[TPP_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_INTERP: prdata = PDATA_W'(reg_interp);
      REG_DECIM:  prdata = PDATA_W'(reg_decim);
      REG_TAPS:   prdata = PDATA_W'(reg_taps);
      default:    prdata = '0;
    endcase
  end

  // Effective factors: zero acts as one, large values clip to the maximum
  logic [IF_W-1:0] ni;
  logic [DF_W-1:0] nd;
  logic [KW-1:0]   nt;

  always_comb begin
    if (reg_interp == '0) begin
      ni = IF_W'(1);
    end else if (32'(reg_interp) > MAX_INTERP) begin
      ni = IF_W'(MAX_INTERP);
    end else begin
      ni = reg_interp;
    end

    if (reg_decim == '0) begin
      nd = DF_W'(1);
    end else if (reg_decim > DF_W'(DECIM_MAX)) begin
      nd = DF_W'(DECIM_MAX);
    end else begin
      nd = reg_decim;
    end

    if (reg_taps == '0) begin
      nt = KW'(1);
    end else if (32'(reg_taps) > MAX_TAPS_PER_PHASE) begin
      nt = KW'(MAX_TAPS_PER_PHASE);
    end else begin
      nt = KW'(reg_taps);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [1:0]     state;
  logic [PW-1:0]  phase;
  logic [TAW-1:0] taddr;       // tap address of the current step: p + I*k
  logic [KW-1:0]  k;           // tap step within the current output
  logic           last_out;    // current output is the last one of its sample
  logic           in_last_q;   // in_last of the sample being worked
  logic           res_ready;   // MAC result held, waiting for the output register
  mac_ctl_t       s1;          // control aligned with the memory read data

  logic           tap_busy;
  logic           sample_acc;
  logic           tap_acc;
  logic           tap_wr;
  logic           has_out;
  logic           start;
  logic           load;
  logic           tap_last;
  logic [PSW-1:0] phase_sum;
  logic           out_last;
  logic [PW-1:0]  phase_after;
  logic [PW-1:0]  phase_skip;

  logic signed [TAP_W-1:0]    tap_rd;
  logic signed [SAMPLE_W-1:0] h_re;
  logic signed [SAMPLE_W-1:0] h_im;
  logic                       mac_done;
  mac_res_t                   mac_res;

  // Take words only when idle and the tap store sweep has finished
  assign in_stall   = (state != S_IDLE) || tap_busy;
  assign sample_acc = in_valid && !in_stall && (in_word.op == OP_SAMPLE);
  assign tap_acc    = in_valid && !in_stall && (in_word.op == OP_TAP);
  assign tap_wr     = tap_acc && (32'(in_word.tap_index) < TAP_DEPTH);

  // Phase bookkeeping: add D for each output, subtract I once per sample (after its last output, or at once if none)
  assign has_out     = phase < PW'(ni);
  assign phase_sum   = PSW'(phase) + PSW'(nd);
  assign out_last    = phase_sum >= PSW'(ni);
  assign phase_after = out_last ? PW'(phase_sum - PSW'(ni)) : PW'(phase_sum);
  assign phase_skip  = phase - PW'(ni);

  assign tap_last = (k + KW'(1)) == nt;

  // Move a finished result into the output register once it is free
  assign load  = (state == S_WAIT) && (mac_done || res_ready) && (!out_valid || !out_stall);
  // Begin an output: on a sample with phase below I, or after loading a non-final one
  assign start = (sample_acc && has_out) || (load && !last_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      res_ready <= 1'b0;
      out_valid <= 1'b0;
      s1        <= '0;
    end else begin
      s1.valid <= (state == S_RUN);
      s1.first <= (k == '0);
      s1.last  <= tap_last;

      if (start) begin
        phase <= phase_after;
      end else if (sample_acc) begin
        phase <= phase_skip;
      end

      if (load) begin
        res_ready <= 1'b0;
      end else if (mac_done) begin
        res_ready <= 1'b1;
      end

      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (tap_last) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (load) begin
            state <= last_out ? S_IDLE : S_RUN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Step address and count: branch p starts at tap p and strides by I
  always_ff @(posedge clk) begin
    if (start) begin
      taddr    <= TAW'(phase);
      k        <= '0;
      last_out <= out_last;
    end else if (state == S_RUN) begin
      taddr <= taddr + TAW'(ni);
      k     <= k + KW'(1);
    end

    if (sample_acc) begin
      in_last_q <= in_word.in_last;
    end

    if (load) begin
      out_word.out_re    <= mac_res.re;
      out_word.out_im    <= mac_res.im;
      out_word.run_last  <= last_out;
      out_word.block_end <= last_out & in_last_q;
      out_word.saturated <= mac_res.sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Storage and arithmetic
  // ---------------------------------------------------------------------------
  prr_tap_mem #(
    .DEPTH (TAP_DEPTH)
  ) u_tap_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tap_wr),
    .wr_addr (TAW'(in_word.tap_index)),
    .wr_data (in_word.tap_value),
    .rd_en   (state == S_RUN),
    .rd_addr (taddr),
    .rd_data (tap_rd),
    .busy    (tap_busy)
  );

  prr_hist_mem #(
    .DEPTH (MAX_TAPS_PER_PHASE)
  ) u_hist_mem (
    .clk      (clk),
    .rst      (rst),
    .push     (sample_acc),
    .push_re  (in_word.sample_re),
    .push_im  (in_word.sample_im),
    .rd_start (start),
    .rd_en    (state == S_RUN),
    .rd_re    (h_re),
    .rd_im    (h_im)
  );

  prr_mac #(
    .MAX_TAPS (MAX_TAPS_PER_PHASE)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .tap  (tap_rd),
    .h_re (h_re),
    .h_im (h_im),
    .ctl  (s1),
    .done (mac_done),
    .res  (mac_res)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_WAIT))
    else $error("MAC finished outside the wait state");

  a_run_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> !res_ready)
    else $error("new output started while a result was still held");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    PSW'(phase) < PSW'(MAX_INTERP + DECIM_MAX))
    else $error("phase counter out of range");

  a_sample_runs: assert property (@(posedge clk) disable iff (rst)
    (sample_acc && has_out) |=> (state == S_RUN))
    else $error("sample with phase below I did not start an output");

endmodule

`default_nettype wire

[tb/sv/prr_checker.sv]
// Scoreboard for the polyphase rational resampler: tracks register writes,
// predicts every output word and compares it with what the block delivers.
// Depends on prr_pkg for word layouts, register codes and opcodes.
`timescale 1ns / 1ps

module prr_checker
  import prr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_word_t           in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_word_t          out_word,
  output int                 pending,
  output int                 fails
);

  localparam int N_BRANCH = 16;
  localparam int N_TAPS   = 32;
  localparam int STORE_N  = N_BRANCH * N_TAPS;

  logic signed [TAP_W-1:0]    tap_copy [STORE_N];
  logic signed [SAMPLE_W-1:0] hist_re  [N_TAPS];
  logic signed [SAMPLE_W-1:0] hist_im  [N_TAPS];
  int                         phase_acc;
  logic        [IF_W-1:0]     interp_reg;
  logic        [DF_W-1:0]     decim_reg;
  logic        [TPP_W-1:0]    taps_reg;
  out_word_t                  expected_words [$];

  function automatic int clamp_field(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Round half up at the Q3.12 point, then clip to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] round_clip(input longint acc,
                                                            output logic clip);
    longint r;
    r    = (acc + (longint'(1) <<< (TAP_FRAC - 1))) >>> TAP_FRAC;
    clip = 1'b0;
    if (r > 32767) begin
      r    = 32767;
      clip = 1'b1;
    end
    if (r < -32768) begin
      r    = -32768;
      clip = 1'b1;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  task automatic clear_state();
    for (int i = 0; i < STORE_N; i++) tap_copy[i] = '0;
    for (int i = 0; i < N_TAPS; i++) begin
      hist_re[i] = '0;
      hist_im[i] = '0;
    end
    phase_acc  = 0;
    interp_reg = IF_W'(1);
    decim_reg  = DF_W'(1);
    taps_reg   = TPP_W'(1);
  endtask

  // Shift the sample in and queue every output it produces.
  task automatic resample_sample(input in_word_t w);
    int        ni, nd, nt, n, ti;
    longint    acc_re, acc_im;
    logic      c_re, c_im;
    out_word_t ow;
    ni = clamp_field(int'(interp_reg), N_BRANCH);
    nd = clamp_field(int'(decim_reg), DECIM_MAX);
    nt = clamp_field(int'(taps_reg), N_TAPS);
    for (int k = N_TAPS - 1; k > 0; k--) begin
      hist_re[k] = hist_re[k-1];
      hist_im[k] = hist_im[k-1];
    end
    hist_re[0] = w.sample_re;
    hist_im[0] = w.sample_im;
    n = 0;
    while (phase_acc < ni && n < N_BRANCH) begin
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < nt; k++) begin
        ti = phase_acc + ni * k;
        if (ti < STORE_N) begin
          acc_re += longint'(tap_copy[ti]) * longint'(hist_re[k]);
          acc_im += longint'(tap_copy[ti]) * longint'(hist_im[k]);
        end
      end
      ow.out_re    = round_clip(acc_re, c_re);
      ow.out_im    = round_clip(acc_im, c_im);
      ow.saturated = c_re | c_im;
      ow.run_last  = (phase_acc + nd >= ni) || (n == N_BRANCH - 1);
      ow.block_end = ow.run_last & w.in_last;
      expected_words.push_back(ow);
      n++;
      phase_acc += nd;
    end
    phase_acc -= ni;
  endtask

  always @(posedge clk) begin : observe
    out_word_t want;
    if (rst) begin
      clear_state();
      expected_words.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_INTERP: interp_reg = pwdata[IF_W-1:0];
          REG_DECIM:  decim_reg  = pwdata[DF_W-1:0];
          REG_TAPS:   taps_reg   = pwdata[TPP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected output word re=%0d im=%0d run_last=%0b block_end=%0b sat=%0b",
                   $time, out_word.out_re, out_word.out_im, out_word.run_last,
                   out_word.block_end, out_word.saturated);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (out_word.out_re !== want.out_re || out_word.out_im !== want.out_im ||
              out_word.run_last !== want.run_last ||
              out_word.block_end !== want.block_end ||
              out_word.saturated !== want.saturated) begin
            $display("%0t: mismatch expected re=%0d im=%0d rl=%0b be=%0b sat=%0b",
                     $time, want.out_re, want.out_im, want.run_last, want.block_end,
                     want.saturated);
            $display("%0t:          actual   re=%0d im=%0d rl=%0b be=%0b sat=%0b",
                     $time, out_word.out_re, out_word.out_im, out_word.run_last,
                     out_word.block_end, out_word.saturated);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_word.op == OP_TAP) tap_copy[in_word.tap_index] = in_word.tap_value;
        else resample_sample(in_word);
      end
    end
    pending = expected_words.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the resampler regression: clock, reset, register writes, stimulus and verdict.
// Depends on prr_pkg, polyphase_rational_resampler and prr_checker.
`timescale 1ns / 1ps

module tb_top;
  import prr_pkg::*;

  // Longest legal quiet stretch is the tap sweep after reset or the
  // forced receiver hold-off; allow several times that.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles to let pass after the last expected word before touching registers,
  // so that trailing work in the block can finish, with margin.
  localparam int SETTLE_CYCLES  = 64;
  localparam int LONG_HOLD      = 600;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_word  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_word;

  int pending;
  int fails;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int quiet_cycles   = 0;

  always #4 clk = ~clk;

  polyphase_rational_resampler dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  prr_checker scoreboard (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .pending   (pending),
    .fails     (fails)
  );

  // Receiver: random back-pressure, plus a long counted hold-off whenever
  // the stimulus bumps hold_req. Exactly one update of out_stall per edge.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic int eff_field(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic signed [TAP_W-1:0] rand_tap();
    // Half the taps between -1.0 and just under +1.0, half anywhere in the Q3.12 range.
    if ($urandom_range(0, 1)) return TAP_W'($urandom_range(0, 65535));
    return TAP_W'($urandom_range(0, 8191) - 4096);
  endfunction

  function automatic in_word_t make_word(input logic op, input int re, input int im,
                                         input logic mark, input int idx, input int val);
    in_word_t w;
    w.op        = op;
    w.sample_re = SAMPLE_W'(re);
    w.sample_im = SAMPLE_W'(im);
    w.in_last   = mark;
    w.tap_index = TIDX_W'(idx);
    w.tap_value = TAP_W'(val);
    return w;
  endfunction

  // Mostly samples with full-range content; tap writes land mostly inside
  // the active part of the store, sometimes anywhere in it.
  function automatic in_word_t rand_item(input int span);
    in_word_t w;
    w.op        = ($urandom_range(0, 99) < 12) ? OP_TAP : OP_SAMPLE;
    w.sample_re = SAMPLE_W'($urandom);
    w.sample_im = SAMPLE_W'($urandom);
    w.in_last   = ($urandom_range(0, 3) == 0);
    w.tap_index = TIDX_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                       : $urandom_range(0, span - 1));
    w.tap_value = rand_tap();
    return w;
  endfunction

  // Offer one word and hold it until the block takes it. Stall is sampled
  // on the falling edge so the decision never races the driving edge.
  task automatic send_word(input in_word_t w);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drop valid, wait for every predicted word, then let trailing work finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup, then access with penable high.
  task automatic cfg_write(input logic [1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram while idle, refresh a few taps, then stream random words.
  task automatic run_phase(input int ni_raw, input int nd_raw, input int nt_raw,
                           input int idle_pct, input int stall_pct, input int n_items);
    int span;
    wait_idle();
    cfg_write(REG_INTERP, ni_raw);
    cfg_write(REG_DECIM, nd_raw);
    cfg_write(REG_TAPS, nt_raw);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    span = eff_field(ni_raw & 'h1F, 16) * eff_field(nt_raw & 'h3F, 32);
    for (int k = 0; k < 8; k++)
      send_word(make_word(OP_TAP, $urandom, $urandom, 1'($urandom_range(0, 1)),
                          $urandom_range(0, span - 1), int'(rand_tap())));
    for (int k = 0; k < n_items; k++) send_word(rand_item(span));
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset configuration I = 1, D = 1, one tap per branch.
    // Taps never written must act as zero.
    send_word(make_word(OP_SAMPLE, 1234, -1234, 1'b0, 0, 0));
    // Tap write carrying junk sample fields and a mark: no output expected.
    send_word(make_word(OP_TAP, 32767, -32768, 1'b1, 0, 4096));
    // Unity tap: full-scale samples pass straight through.
    send_word(make_word(OP_SAMPLE, 32767, -32768, 1'b1, 0, 0));
    send_word(make_word(OP_SAMPLE, -32768, 32767, 1'b0, 0, 0));
    // Largest positive tap drives both parts into the negative clip.
    send_word(make_word(OP_TAP, 0, 0, 1'b0, 0, 32767));
    send_word(make_word(OP_SAMPLE, -32768, -32768, 1'b1, 0, 0));
    // Most negative tap: positive clip on one part, negative on the other.
    send_word(make_word(OP_TAP, 0, 0, 1'b0, 0, -32768));
    send_word(make_word(OP_SAMPLE, -32768, 32767, 1'b0, 0, 0));
    // Smallest tap exercises the half-up rounding edges.
    send_word(make_word(OP_TAP, 0, 0, 1'b0, 0, 1));
    send_word(make_word(OP_SAMPLE, 2048, -2048, 1'b0, 0, 0));
    send_word(make_word(OP_SAMPLE, 2047, -2049, 1'b1, 0, 0));
    // Top of the store, unused at this setting.
    send_word(make_word(OP_TAP, 0, 0, 1'b0, 511, -32767));

    // Directed, D > I: some samples emit nothing, including marked ones.
    wait_idle();
    cfg_write(REG_INTERP, 2);
    cfg_write(REG_DECIM, 3);
    cfg_write(REG_TAPS, 2);
    send_word(make_word(OP_TAP, 0, 0, 1'b0, 0, 4096));
    send_word(make_word(OP_TAP, 0, 0, 1'b0, 1, 2048));
    send_word(make_word(OP_TAP, 0, 0, 1'b0, 2, -4096));
    send_word(make_word(OP_TAP, 0, 0, 1'b0, 3, 1000));
    for (int k = 0; k < 6; k++)
      send_word(make_word(OP_SAMPLE, 5000 * k - 12000, 20000 - 7000 * k, 1'b1, 0, 0));

    // Random phases: no idling, sender idle, receiver stalling.
    run_phase(2, 3, 3, 0, 0, 10);
    run_phase(5, 3, 8, 59, 0, 10);
    run_phase(4, 7, 2, 0, 59, 10);

    // Hold the receiver off for a long stretch while the sender keeps
    // offering, so the block backs up and stalls its input.
    run_phase(3, 1, 6, 21, 21, 8);
    hold_req++;
    for (int k = 0; k < 10; k++) send_word(rand_item(18));
    // Sender pause until every expected word has arrived.
    wait_idle();
    for (int k = 0; k < 8; k++) send_word(rand_item(18));

    // Register extremes: zeros act as one, overlarge values as the maximum.
    run_phase(0, 0, 0, 21, 21, 12);
    run_phase(31, 1, 63, 0, 0, 6);
    run_phase(16, 511, 1, 59, 0, 16);
    // Lower I while the phase sits far above it.
    run_phase(9, 256, 5, 0, 59, 16);
    run_phase(1, 1, 32, 21, 21, 16);

    wait_idle();
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/prr_pkg.sv
hw/rtl/prr_tap_mem.sv
hw/rtl/prr_hist_mem.sv
hw/rtl/prr_mac.sv
hw/rtl/polyphase_rational_resampler.sv
tb/sv/prr_checker.sv
tb/sv/tb_top.sv
